// File: rtl/core/assert_macros.svh
// assertion helpers for the tone curve block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/htc_pkg.sv
package htc_pkg;

    localparam int PIX_W   = 24;
    localparam int OUT_W   = 16;
    localparam int COEF_W  = 32;
    localparam int LINE_W  = 64;
    localparam int KNEE_W  = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // quotient bits resolved by the divider, one per stage
    localparam int QUOT_W  = 34;
    // register stages inside one channel
    localparam int CHAN_LAT = QUOT_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOE_SCALE      = 3'd0,
        REG_TOE_SHIFT      = 3'd1,
        REG_TOE_LIFT       = 3'd2,
        REG_SHOULDER_SCALE = 3'd3,
        REG_SHOULDER_SHIFT = 3'd4,
        REG_SHOULDER_LIFT  = 3'd5,
        REG_MID_LINE       = 3'd6,
        REG_KNEE_POINTS    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] toe_scale;
        logic signed [COEF_W-1:0] toe_shift;
        logic signed [COEF_W-1:0] toe_lift;
        logic signed [COEF_W-1:0] shoulder_scale;
        logic signed [COEF_W-1:0] shoulder_shift;
        logic signed [COEF_W-1:0] shoulder_lift;
        logic [LINE_W-1:0]        mid_line;
        logic [KNEE_W-1:0]        knee_points;
    } coef_t;

endpackage

// File: rtl/core/htc_pix_in_if.sv
interface htc_pix_in_if;
    logic                      valid;
    logic                      ready;
    logic [htc_pkg::PIX_W-1:0] red_in;
    logic [htc_pkg::PIX_W-1:0] green_in;
    logic [htc_pkg::PIX_W-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

// File: rtl/core/htc_pix_out_if.sv
interface htc_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [htc_pkg::OUT_W-1:0] red_out;
    logic [htc_pkg::OUT_W-1:0] green_out;
    logic [htc_pkg::OUT_W-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: rtl/core/htc_cfg_if.sv
interface htc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [htc_pkg::CFG_IDX_W-1:0]  index;
    logic [htc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/htc_chan.sv
module htc_chan (
    input  logic                      clk,
    input  logic                      en,
    input  htc_pkg::coef_t            coef,
    input  logic [htc_pkg::PIX_W-1:0] x,
    output logic [htc_pkg::OUT_W-1:0] y
);
    localparam int QW = htc_pkg::QUOT_W;
    localparam int CW = htc_pkg::COEF_W;
    localparam int XW = htc_pkg::PIX_W;
    localparam int DW = CW + 1;
    localparam int NW = CW + 16;
    localparam int PW = CW + XW + 1;
    localparam int WW = PW + 1;
    localparam int VW = QW + 3;
    localparam int OW = htc_pkg::OUT_W;

    typedef enum logic [1:0] {SEG_TOE, SEG_LINE, SEG_SHOULDER} seg_t;

    // saturate a Q.1 value to the output range, rounding half up
    function automatic logic [OW-1:0] clamp_q1(input logic signed [VW-1:0] v);
        logic [VW-1:0] u;
        begin
            u = VW'(v) + VW'(1);
            u = u >> 1;
            if (v <= 0)
                clamp_q1 = '0;
            else if (u > VW'(16'hFFFF))
                clamp_q1 = '1;
            else
                clamp_q1 = u[OW-1:0];
        end
    endfunction

    // saturate a Q.32 line value to the output range, rounding half up
    function automatic logic [OW-1:0] clamp_q32(input logic signed [WW-1:0] w);
        logic [WW-1:0] u;
        begin
            u = WW'(w) + (WW'(1) << 16);
            u = u >> 17;
            if (w <= 0)
                clamp_q32 = '0;
            else if (u > WW'(16'hFFFF))
                clamp_q32 = '1;
            else
                clamp_q32 = u[OW-1:0];
        end
    endfunction

    // front: segment choice and coefficient select
    logic [XW-1:0]         knee1;
    logic [XW-1:0]         knee2;
    seg_t                  seg;
    logic signed [CW-1:0]  a_sel;
    logic signed [CW-1:0]  b_sel;
    logic signed [CW-1:0]  c_sel;

    assign knee1 = coef.knee_points[XW-1:0];
    assign knee2 = coef.knee_points[2*XW-1:XW];

    always_comb
    begin
        if (x >= knee2)
            seg = SEG_SHOULDER;
        else if (x >= knee1)
            seg = SEG_LINE;
        else
            seg = SEG_TOE;
        if (seg == SEG_SHOULDER)
        begin
            a_sel = coef.shoulder_scale;
            b_sel = coef.shoulder_shift;
            c_sel = coef.shoulder_lift;
        end
        else
        begin
            a_sel = coef.toe_scale;
            b_sel = coef.toe_shift;
            c_sel = coef.toe_lift;
        end
    end

    // stage 0: denominator x + b
    logic [XW-1:0]         x0_reg;
    seg_t                  seg0_reg;
    logic signed [CW-1:0]  a0_reg;
    logic signed [DW-1:0]  d0_reg;
    logic signed [CW-1:0]  c0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= x;
            seg0_reg <= seg;
            a0_reg   <= a_sel;
            d0_reg   <= $signed({{(DW-XW){1'b0}}, x}) + $signed({b_sel[CW-1], b_sel});
            c0_reg   <= c_sel;
        end
    end

    // stage 1: magnitudes, overflow test, line product
    logic [CW-1:0]         amag;
    logic [DW-1:0]         dmag;
    logic [NW-1:0]         num;
    logic signed [CW-1:0]  slope;
    logic signed [PW-1:0]  prod;

    assign amag  = a0_reg[CW-1] ? CW'(-a0_reg) : CW'(a0_reg);
    assign dmag  = d0_reg[DW-1] ? DW'(-d0_reg) : DW'(d0_reg);
    assign num   = {amag, 16'b0};
    assign slope = coef.mid_line[2*CW-1:CW];
    assign prod  = $signed({{(PW-CW){slope[CW-1]}}, slope})
                 * $signed({{(PW-XW){1'b0}}, x0_reg});

    // divider pipeline, one quotient bit per stage
    logic [DW-1:0]         rem_reg  [QW+1];
    logic [QW-1:0]         nlo_reg  [QW+1];
    logic [QW-1:0]         quo_reg  [QW+1];
    logic [DW-1:0]         dm_reg   [QW+1];
    logic                  neg_reg  [QW+1];
    logic                  dz_reg   [QW+1];
    logic                  ovf_reg  [QW+1];
    logic                  an_reg   [QW+1];
    seg_t                  seg_reg  [QW+1];
    logic signed [CW-1:0]  c_reg    [QW+1];
    logic signed [PW-1:0]  prod_reg [QW+1];

    logic [DW:0]           trial    [QW];
    logic [DW-1:0]         rem_next [QW];
    logic                  qbit     [QW];

    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            trial[i] = {rem_reg[i], nlo_reg[i][QW-1]};
            qbit[i]  = trial[i] >= {1'b0, dm_reg[i]};
            rem_next[i] = qbit[i] ? DW'(trial[i] - {1'b0, dm_reg[i]}) : DW'(trial[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DW'(num[NW-1:QW]);
            nlo_reg[0]  <= num[QW-1:0];
            quo_reg[0]  <= '0;
            dm_reg[0]   <= dmag;
            neg_reg[0]  <= a0_reg[CW-1] ^ d0_reg[DW-1];
            dz_reg[0]   <= (d0_reg == '0);
            ovf_reg[0]  <= DW'(num[NW-1:QW]) >= dmag;
            an_reg[0]   <= a0_reg[CW-1];
            seg_reg[0]  <= seg0_reg;
            c_reg[0]    <= c0_reg;
            prod_reg[0] <= prod;
            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i+1]  <= rem_next[i];
                nlo_reg[i+1]  <= {nlo_reg[i][QW-2:0], 1'b0};
                quo_reg[i+1]  <= {quo_reg[i][QW-2:0], qbit[i]};
                dm_reg[i+1]   <= dm_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                dz_reg[i+1]   <= dz_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                an_reg[i+1]   <= an_reg[i];
                seg_reg[i+1]  <= seg_reg[i];
                c_reg[i+1]    <= c_reg[i];
                prod_reg[i+1] <= prod_reg[i];
            end
        end
    end

    // final: offset, line sum, saturation
    logic [QW:0]           qmag;
    logic signed [VW-1:0]  qs;
    logic signed [VW-1:0]  v;
    logic signed [WW-1:0]  w;
    logic signed [CW-1:0]  icpt;
    logic [OW-1:0]         hyp;

    assign qmag = ovf_reg[QW] ? ((QW+1)'(1) << QW) : {1'b0, quo_reg[QW]};
    assign qs   = neg_reg[QW] ? -$signed(VW'(qmag)) : $signed(VW'(qmag));
    assign v    = $signed(VW'(c_reg[QW])) - qs;
    assign icpt = coef.mid_line[CW-1:0];
    assign w    = $signed(WW'(prod_reg[QW])) + ($signed(WW'(icpt)) <<< 16);
    assign hyp  = dz_reg[QW] ? (an_reg[QW] ? '1 : '0) : clamp_q1(v);
    assign y    = (seg_reg[QW] == SEG_LINE) ? clamp_q32(w) : hyp;

endmodule

// File: rtl/core/hyperbolic_tone_curve_top.sv
// three-segment tone curve for linear HDR RGB pixels
// pix_in carries one pixel item (red_in, green_in, blue_in, unsigned Q8.16);
// pix_out carries the mapped item (red_out, green_out, blue_out, Q1.15).
// cfg writes coefficient registers by index; it is always ready and
// should only be used while no item is in flight.
// each channel has a 34-stage restoring divider, one quotient bit a stage,
// behind a select/add stage and a magnitude/multiply stage.
// throughput: one item per cycle while pix_out is not stalled; the divider pipeline sets the latency.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and pix_in.ready drops; nothing is lost or repeated.
// reset clears the valid bits and the coefficient registers to zero.
`include "assert_macros.svh"

module hyperbolic_tone_curve_top (
    input  logic   clk,
    input  logic   rst_n,
    htc_pix_in_if.sink    pix_in,
    htc_pix_out_if.source pix_out,
    htc_cfg_if.sink       cfg
);
    localparam int LAT = htc_pkg::CHAN_LAT;
    localparam int OW  = htc_pkg::OUT_W;

    htc_pkg::coef_t  coef_reg;
    logic            en;
    logic [LAT-1:0]  vld_reg;
    logic            out_vld_reg;
    logic [OW-1:0]   red_reg;
    logic [OW-1:0]   green_reg;
    logic [OW-1:0]   blue_reg;
    logic [OW-1:0]   red_y;
    logic [OW-1:0]   green_y;
    logic [OW-1:0]   blue_y;

    // pipeline moves unless a result waits unread
    assign en           = !out_vld_reg || pix_out.ready;
    assign pix_in.ready = en;
    assign cfg.ready    = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= '0;
        else if (cfg.valid)
        begin
            case (htc_pkg::cfg_idx_t'(cfg.index))
                htc_pkg::REG_TOE_SCALE:      coef_reg.toe_scale      <= cfg.data[31:0];
                htc_pkg::REG_TOE_SHIFT:      coef_reg.toe_shift      <= cfg.data[31:0];
                htc_pkg::REG_TOE_LIFT:       coef_reg.toe_lift       <= cfg.data[31:0];
                htc_pkg::REG_SHOULDER_SCALE: coef_reg.shoulder_scale <= cfg.data[31:0];
                htc_pkg::REG_SHOULDER_SHIFT: coef_reg.shoulder_shift <= cfg.data[31:0];
                htc_pkg::REG_SHOULDER_LIFT:  coef_reg.shoulder_lift  <= cfg.data[31:0];
                htc_pkg::REG_MID_LINE:       coef_reg.mid_line       <= cfg.data;
                htc_pkg::REG_KNEE_POINTS:
                    coef_reg.knee_points <= cfg.data[htc_pkg::KNEE_W-1:0];
                default: ;
            endcase
        end
    end

    // per-channel datapaths
    htc_chan u_red (.clk(clk), .en(en), .coef(coef_reg), .x(pix_in.red_in), .y(red_y));
    htc_chan u_green (.clk(clk), .en(en), .coef(coef_reg), .x(pix_in.green_in), .y(green_y));
    htc_chan u_blue (.clk(clk), .en(en), .coef(coef_reg), .x(pix_in.blue_in), .y(blue_y));

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LAT-2:0], pix_in.valid};
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_y;
            green_reg <= green_y;
            blue_reg  <= blue_y;
        end
    end

    assign pix_out.valid     = out_vld_reg;
    assign pix_out.red_out   = red_reg;
    assign pix_out.green_out = green_reg;
    assign pix_out.blue_out  = blue_reg;

    // checks
    `ASSERT_IMPLY(a_stall_only_full, clk, rst_n, !pix_in.ready, out_vld_reg && !pix_out.ready)
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, pix_in.valid && pix_in.ready, vld_reg[0])
    `ASSERT_NEXT(a_exit_shows, clk, rst_n, en && vld_reg[LAT-1], pix_out.valid)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(vld_reg))

endmodule

// File: tb/htc_tb_if.sv
`timescale 1ns / 100ps

// the block's interfaces come with the rtl; nothing extra is needed here
// beyond typed pixel and tone items for the stimulus queue and the result checks
package htc_tb_pkg;
    typedef struct packed {
        logic [23:0] red;
        logic [23:0] green;
        logic [23:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } tone_t;
endpackage

// File: tb/tb_hyperbolic_tone_curve_top.sv
`timescale 1ns / 100ps

module tb_hyperbolic_tone_curve_top;

    localparam int LATENCY = 37;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    htc_pix_in_if  pix_in ();
    htc_pix_out_if pix_out ();
    htc_cfg_if     cfg ();

    hyperbolic_tone_curve_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    // shadow copy of the coefficient registers
    logic signed [31:0] toe_a, toe_b, toe_c, sh_a, sh_b, sh_c;
    logic [63:0] line_reg;
    logic [47:0] knee_reg;

    htc_tb_pkg::pixel_t pending_pixels[$];
    htc_tb_pkg::tone_t  expected_tones[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_send;
    int     errors = 0;
    int     accepted = 0;
    int     checked = 0;
    int     cycles = 0;

    // clock and cycle limit
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] saturate(input logic signed [71:0] v, input int drop);
        logic signed [71:0] r;
        begin
            if (v <= 0)
                return 16'd0;
            r = (v + (72'sd1 <<< (drop - 1))) >>> drop;
            return (r > 65535) ? 16'hFFFF : r[15:0];
        end
    endfunction

    function automatic logic [15:0] hyper_seg(input logic [23:0] x, input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic signed [31:0] c);
        logic signed [71:0] d;
        logic signed [71:0] q;
        begin
            d = $signed({48'd0, x}) + b;
            if (d == 0)
                return (a < 0) ? 16'hFFFF : 16'd0;
            q = ($signed({{40{a[31]}}, a}) * 72'sd65536) / d;
            return saturate(c - q, 1);
        end
    endfunction

    function automatic logic [15:0] map_channel(input logic [23:0] x);
        logic signed [31:0] slope, icept;
        logic signed [71:0] w;
        begin
            slope = line_reg[63:32];
            icept = line_reg[31:0];
            if (x >= knee_reg[47:24])
                return hyper_seg(x, sh_a, sh_b, sh_c);
            if (x >= knee_reg[23:0])
            begin
                w = slope * $signed({48'd0, x}) + icept * 72'sd65536;
                return saturate(w, 17);
            end
            return hyper_seg(x, toe_a, toe_b, toe_c);
        end
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_in.valid <= 1'b0;
            pix_in.red_in <= '0;
            pix_in.green_in <= '0;
            pix_in.blue_in <= '0;
        end
        else
        begin
            htc_tb_pkg::pixel_t p;
            if (pix_in.valid && pix_in.ready)
            begin
                expected_tones.push_back({map_channel(pix_in.red_in),
                                          map_channel(pix_in.green_in),
                                          map_channel(pix_in.blue_in)});
                accepted <= accepted + 1;
            end
            if (!pix_in.valid || pix_in.ready)
            begin
                if (pending_pixels.size() > 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    p = pending_pixels.pop_front();
                    pix_in.valid <= 1'b1;
                    pix_in.red_in <= p.red;
                    pix_in.green_in <= p.green;
                    pix_in.blue_in <= p.blue;
                end
                else
                    pix_in.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_out.ready <= 1'b0;
        else
        begin
            htc_tb_pkg::tone_t e;
            if (pix_out.valid && pix_out.ready)
            begin
                checked <= checked + 1;
                if (expected_tones.size() == 0)
                begin
                    $error("result with no expectation");
                    errors++;
                end
                else
                begin
                    e = expected_tones.pop_front();
                    if (pix_out.red_out !== e.red)
                    begin
                        $error("red_out expected %0d got %0d", e.red, pix_out.red_out);
                        errors++;
                    end
                    if (pix_out.green_out !== e.green)
                    begin
                        $error("green_out expected %0d got %0d", e.green, pix_out.green_out);
                        errors++;
                    end
                    if (pix_out.blue_out !== e.blue)
                    begin
                        $error("blue_out expected %0d got %0d", e.blue, pix_out.blue_out);
                        errors++;
                    end
                end
            end
            pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // polled between edges so that the driver's updates have settled
    task automatic wait_drained();
        begin
            while (pending_pixels.size() > 0 || pix_in.valid || expected_tones.size() > 0)
                @(negedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input htc_pkg::cfg_idx_t idx, input logic [63:0] value);
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idx;
            cfg.data <= value;
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            cfg.valid <= 1'b0;
            case (idx)
                htc_pkg::REG_TOE_SCALE:      toe_a = value[31:0];
                htc_pkg::REG_TOE_SHIFT:      toe_b = value[31:0];
                htc_pkg::REG_TOE_LIFT:       toe_c = value[31:0];
                htc_pkg::REG_SHOULDER_SCALE: sh_a = value[31:0];
                htc_pkg::REG_SHOULDER_SHIFT: sh_b = value[31:0];
                htc_pkg::REG_SHOULDER_LIFT:  sh_c = value[31:0];
                htc_pkg::REG_MID_LINE:       line_reg = value;
                htc_pkg::REG_KNEE_POINTS:    knee_reg = value[47:0];
                default: ;
            endcase
            @(posedge clk);
        end
    endtask

    function automatic logic [23:0] rand_x();
        case ($urandom_range(5))
            0: return 24'($urandom_range(255));
            1: return 24'(24'hFFFFFF - $urandom_range(255));
            2: return 24'(knee_reg[23:0] + $urandom_range(3) - 2);
            3: return 24'(knee_reg[47:24] + $urandom_range(3) - 2);
            4: return 24'(24'd0 - toe_b[23:0] + $urandom_range(2) - 1);
            default: return 24'($urandom);
        endcase
    endfunction

    // a plausible curve with random coefficients, or limit scales and shifts when extreme
    task automatic random_curve(input bit extreme);
        logic [23:0] k1, k2;
        begin
            k1 = 24'($urandom_range(24'h3FFFF));
            k2 = 24'(k1 + $urandom_range(24'h7FFFF));
            if ($urandom_range(7) == 0)
                k2 = 24'($urandom);
            write_reg(htc_pkg::REG_TOE_SCALE,
                      extreme ? {32'd0, 32'h80000000} : {32'd0, $urandom});
            write_reg(htc_pkg::REG_TOE_SHIFT, extreme ? {32'd0, 32'h7FFFFFFF} :
                      {32'd0, 32'($signed($urandom_range(400000)) - 200000)});
            write_reg(htc_pkg::REG_TOE_LIFT, {32'd0, $urandom});
            write_reg(htc_pkg::REG_SHOULDER_SCALE,
                      extreme ? {32'd0, 32'h7FFFFFFF} : {32'd0, $urandom});
            write_reg(htc_pkg::REG_SHOULDER_SHIFT, extreme ? {32'd0, 32'h80000000} :
                      {32'd0, 32'($signed($urandom_range(4000000)) - 2000000)});
            write_reg(htc_pkg::REG_SHOULDER_LIFT, {32'd0, $urandom});
            write_reg(htc_pkg::REG_MID_LINE, {$urandom, $urandom});
            write_reg(htc_pkg::REG_KNEE_POINTS, {k2, k1});
        end
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        {toe_a, toe_b, toe_c, sh_a, sh_b, sh_c} = '0;
        line_reg = '0;
        knee_reg = '0;
        hold_send = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 53;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: every divisor zero at x = 0, shoulder everywhere
        pending_pixels.push_back('{24'd0, 24'hFFFFFF, 24'd1});
        wait_drained();

        // directed: toe with zero divisor, both scale signs, knee edges
        write_reg(htc_pkg::REG_TOE_SCALE, {32'd0, 32'hFFFF0000});
        write_reg(htc_pkg::REG_TOE_SHIFT, {32'd0, 32'hFFFF0000});
        write_reg(htc_pkg::REG_TOE_LIFT, {32'd0, 32'h00010000});
        write_reg(htc_pkg::REG_SHOULDER_SCALE, {32'd0, 32'h00020000});
        write_reg(htc_pkg::REG_SHOULDER_SHIFT, {32'd0, 32'h00010000});
        write_reg(htc_pkg::REG_SHOULDER_LIFT, {32'd0, 32'h00018000});
        write_reg(htc_pkg::REG_MID_LINE, {32'h00008000, 32'h00002000});
        write_reg(htc_pkg::REG_KNEE_POINTS, {24'h040000, 24'h020000});
        pending_pixels.push_back('{24'h010000, 24'h01FFFF, 24'h020000});
        pending_pixels.push_back('{24'h03FFFF, 24'h040000, 24'hFFFFFF});
        pending_pixels.push_back('{24'd0, 24'h00FFFF, 24'h010001});
        pending_pixels.push_back('{24'hAAAAAA, 24'h555555, 24'h7FFFFF});
        wait_drained();
        write_reg(htc_pkg::REG_TOE_SCALE, {32'd0, 32'h00010000});
        write_reg(htc_pkg::REG_MID_LINE, {32'h80000000, 32'h7FFFFFFF});
        // second knee below the first: line segment empty
        write_reg(htc_pkg::REG_KNEE_POINTS, {24'h010000, 24'h030000});
        pending_pixels.push_back('{24'h010000, 24'h020000, 24'h00FFFF});
        pending_pixels.push_back('{24'h030000, 24'hFFFFFF, 24'd0});
        wait_drained();
        write_reg(htc_pkg::REG_MID_LINE, {32'h7FFFFFFF, 32'h80000000});
        write_reg(htc_pkg::REG_KNEE_POINTS, {24'hFFFFFF, 24'd0});
        pending_pixels.push_back('{24'd0, 24'hFFFFFE, 24'hFFFFFF});
        pending_pixels.push_back('{24'h123456, 24'h800000, 24'h000001});
        wait_drained();

        // random phases over idling profiles and coefficient sets
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph / 3)
                0: begin send_idle_pct = 28; recv_idle_pct = 53; end
                1: begin send_idle_pct = 53; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_curve(ph == 4);
            n = 95;
            for (int i = 0; i < n; i++)
            begin
                pending_pixels.push_back('{rand_x(), rand_x(), rand_x()});
                if (ph == 2 && i == 50)
                begin
                    // let the pipe drain fully before sending more
                    while (pending_pixels.size() > 0 || pix_in.valid)
                        @(negedge clk);
                    hold_send = 1'b1;
                    while (expected_tones.size() > 0)
                        @(negedge clk);
                    hold_send = 1'b0;
                end
            end
            wait_drained();
        end

        $display("ran %0d pixels through %0d checks over reset, directed and random curves",
                 accepted, checked);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/htc_pkg.sv
rtl/core/htc_pix_in_if.sv
rtl/core/htc_pix_out_if.sv
rtl/core/htc_cfg_if.sv
rtl/core/htc_chan.sv
rtl/core/hyperbolic_tone_curve_top.sv
tb/htc_tb_if.sv
tb/tb_hyperbolic_tone_curve_top.sv
